### src/cerq_pkg.sv
// shared types and constants for the coalescing event ring queue
// no dependencies; imported by the top level

package cerq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_W         = 5;
   localparam int CODE_W        = 3;
   localparam int STATUS_W      = 2;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      MODE_ENQ     = 2'd0,
      MODE_DEQ     = 2'd1,
      MODE_SET_OVL = 2'd2,
      MODE_CLR_OVL = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [CODE_W-1:0] event_out;
      logic              is_empty;
      logic              overlay_on;
   } rsp_type;

endpackage

### src/cerq_ram.sv
// generic single-write, single-read ram with registered read data
// read during write to the same address returns the old data; no dependencies

module cerq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/coalescing_event_ring_queue_top.sv
// coalescing event ring queue: ring fifo of event codes with an overlay slot
// depends on cerq_pkg and cerq_ram
//
// result timing: a result is on rsp_ in the cycle after its request transfer when the
//    output register is free; otherwise it waits in the skid stage behind it
// throughput: one operation per cycle; the slot ram is read every cycle at the
//    next read pointer, so a dequeue finds its code already registered;
//    req_ready drops while a result waits in the skid stage
// reset: synchronous, clears pointers, overlay state and the result stages and
//    sets capacity to 16; slot contents stay undefined until written

module coalescing_event_ring_queue_top
   import cerq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [CODE_W-1:0] req_event_code,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CODE_W-1:0]   rsp_event_out,
   output logic                rsp_is_empty,
   output logic                rsp_overlay_on,
   // capacity register
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data
);

   // pointer width, and a width that holds pointer+1, DEPTH and capacity
   localparam int PTR_W = $clog2(DEPTH);
   localparam int LW    = (CAP_W > PTR_W + 1) ? CAP_W : PTR_W + 1;

   // ring pointer advance against the ring length in use
   function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                            input logic [LW-1:0]    n);
      logic [LW-1:0] nx;
      nx = LW'(p) + LW'(1);
      return (nx >= n) ? '0 : nx[PTR_W-1:0];
   endfunction

   // control state
   logic [CAP_W-1:0] capacity_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             ovl_flag_ff, ovl_flag_in;
   logic [PTR_W-1:0] ovl_slot_ff, ovl_slot_in;

   // read-during-write forwarding for the prefetched head slot
   logic              fwd_valid_ff;
   logic [CODE_W-1:0] fwd_data_ff;

   // result register and skid stage
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   rsp_type rsp_new;

   // ram port signals
   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [CODE_W-1:0] ram_rd_data;
   logic [CODE_W-1:0] head_code;

   // datapath helpers
   logic [LW-1:0]    cap_ext;
   logic [LW-1:0]    ring_len;
   logic [PTR_W-1:0] wp_adv;
   logic [PTR_W-1:0] wp_skip;
   logic [PTR_W-1:0] wp_skip_adv;
   logic [PTR_W-1:0] os_adv;
   logic [PTR_W-1:0] rp_adv;
   logic             req_xfer;
   logic             rsp_xfer;
   logic             out_free;
   logic             full;
   logic             empty;
   mode_type         mode;

   // ring length: zero acts as one, values above DEPTH act as DEPTH
   assign cap_ext  = LW'(capacity_ff);
   assign ring_len = (cap_ext == '0)          ? LW'(1) :
                     (cap_ext > LW'(DEPTH))   ? LW'(DEPTH) : cap_ext;

   assign wp_adv      = adv(wr_ptr_ff, ring_len);
   // in overlay, the first enqueue steps over the reserved slot
   assign wp_skip     = (ovl_slot_ff == wr_ptr_ff) ? wp_adv : wr_ptr_ff;
   assign wp_skip_adv = adv(wp_skip, ring_len);
   assign os_adv      = adv(ovl_slot_ff, ring_len);
   assign rp_adv      = adv(rd_ptr_ff, ring_len);

   assign full  = (wp_adv == rd_ptr_ff);
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign mode  = mode_type'(req_mode);

   // one result may wait in the skid stage while the output register is held
   assign req_ready = !skid_valid_ff && !reset;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign out_free  = !rsp_valid_ff || rsp_xfer;

   // head slot: ram data, unless it was written in the cycle it was read
   assign head_code = fwd_valid_ff ? fwd_data_ff : ram_rd_data;

   // operation decode and next state
   always_comb begin
      wr_ptr_in          = wr_ptr_ff;
      rd_ptr_in          = rd_ptr_ff;
      ovl_flag_in        = ovl_flag_ff;
      ovl_slot_in        = ovl_slot_ff;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = wr_ptr_ff;
      rsp_new.status     = STATUS_OK;
      rsp_new.event_out  = '0;
      if (req_xfer) begin
         unique case (mode)
            MODE_ENQ: begin
               if (full) begin
                  rsp_new.status = STATUS_FULL;
               end else if (ovl_flag_ff) begin
                  ram_wr_en = 1'b1;
                  if (wp_skip == rd_ptr_ff) begin
                     // consumer drained past the reserved slot: plain enqueue
                     ovl_slot_in = os_adv;
                     wr_ptr_in   = wp_skip_adv;
                     ovl_flag_in = 1'b0;
                     ram_wr_addr = os_adv;
                  end else begin
                     wr_ptr_in   = wp_skip;
                     ram_wr_addr = ovl_slot_ff;
                  end
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = wr_ptr_ff;
                  wr_ptr_in   = wp_adv;
               end
            end
            MODE_DEQ: begin
               if (empty) begin
                  rsp_new.status = STATUS_EMPTY;
               end else begin
                  rsp_new.event_out = head_code;
                  rd_ptr_in         = rp_adv;
               end
            end
            MODE_SET_OVL: begin
               if (!ovl_flag_ff) begin
                  ovl_flag_in = 1'b1;
                  ovl_slot_in = wr_ptr_ff;
               end
            end
            MODE_CLR_OVL: begin
               ovl_flag_in = 1'b0;
               ovl_slot_in = '0;
            end
            default: begin
               ovl_flag_in = ovl_flag_ff;
            end
         endcase
      end
      rsp_new.is_empty   = (wr_ptr_in == rd_ptr_in);
      rsp_new.overlay_on = ovl_flag_in;
   end

   // prefetch the slot that will be the head next cycle
   assign ram_rd_addr = reset ? '0 : rd_ptr_in;

   cerq_ram #(
      .WIDTH (CODE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_event_code),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         ovl_flag_ff  <= 1'b0;
         ovl_slot_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         ovl_flag_ff  <= ovl_flag_in;
         ovl_slot_ff  <= ovl_slot_in;
         fwd_valid_ff <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
      end
   end

   // forwarded code needs no reset
   always_ff @(posedge clock) begin
      fwd_data_ff <= req_event_code;
   end

   // result register and skid stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || req_xfer;
         skid_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : rsp_new;
      end else if (req_xfer) begin
         skid_data_ff <= rsp_new;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_event_out  = rsp_data_ff.event_out;
   assign rsp_is_empty   = rsp_data_ff.is_empty;
   assign rsp_overlay_on = rsp_data_ff.overlay_on;

   // a waiting skid entry always sits behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds a result with an empty output register");

   // a request transfer into a free output shows up as a result next cycle
   a_xfer_to_out: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("request transfer produced no result");

   // a rejected enqueue leaves the write pointer alone
   a_full_holds_wp: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && mode == MODE_ENQ && full) |=> $stable(wr_ptr_ff))
      else $error("write pointer moved on a full enqueue");

   // a dequeue from an empty ring leaves the read pointer alone
   a_empty_holds_rp: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && mode == MODE_DEQ && empty) |=> $stable(rd_ptr_ff))
      else $error("read pointer moved on an empty dequeue");

endmodule
